@@ rtl/tlpe_pkg.sv @@
`default_nettype none
package tlpe_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int COORD_BITS = 16;

  localparam int W_W    = FRAC_BITS + 1;
  localparam int NRM_W  = FRAC_BITS + 2;
  localparam int MAG_W  = COORD_BITS;
  localparam int P_W    = $clog2(MAG_W);
  localparam int NMAG_W = 30;
  localparam int SQ_W   = 2 * NMAG_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int RAD_W  = ((SUM_W + 3) / 4) * 4;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SQ_CYC = ROOT_W / 2;
  localparam int SQ_CNT_W = $clog2(SQ_CYC);

  localparam int QW      = W_W + (W_W % 2);
  localparam int DEN_W   = ROOT_W + 1;
  localparam int NUM_W   = NMAG_W + W_W + 1;
  localparam int DSH_W   = DEN_W + QW - 1;
  localparam int DV_CYC  = QW / 2;
  localparam int DV_CNT_W = $clog2(DV_CYC);

  localparam int PSUM_W = ((COORD_BITS > QW) ? COORD_BITS : QW) + 2;
  localparam int FIFO_DEPTH = 2;

  localparam logic [FRAC_BITS-1:0] HT_BASE_RAISED =
    FRAC_BITS'(((15 << FRAC_BITS) + 500) / 1000);
  localparam logic [FRAC_BITS-1:0] HT_TOP_RAISED =
    FRAC_BITS'(((80 << FRAC_BITS) + 500) / 1000);
  localparam logic [FRAC_BITS-1:0] HT_BASE_FLAT = '0;
  localparam logic [FRAC_BITS-1:0] HT_TOP_FLAT =
    FRAC_BITS'(((2 << FRAC_BITS) + 500) / 1000);
  localparam logic [FRAC_BITS:0] NORM_ONE = (W_W)'(1 << FRAC_BITS);

  localparam logic [2:0] FACE_TOP   = 3'd0;
  localparam logic [2:0] FACE_LEFT  = 3'd1;
  localparam logic [2:0] FACE_RIGHT = 3'd2;
  localparam logic [2:0] FACE_NEAR  = 3'd3;
  localparam logic [2:0] FACE_FAR   = 3'd4;
  localparam logic [2:0] J_LAST     = 3'd5;

  localparam logic [1:0] CRN_A = 2'd0;
  localparam logic [1:0] CRN_B = 2'd1;
  localparam logic [1:0] CRN_C = 2'd2;
  localparam logic [1:0] CRN_E = 2'd3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_depth;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_depth;
    logic [FRAC_BITS:0]           width;
  } tlpe_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic [FRAC_BITS-1:0]         pos_height;
    logic signed [COORD_BITS-1:0] pos_depth;
    logic signed [NRM_W-1:0]      norm_x;
    logic [FRAC_BITS:0]           norm_y;
    logic signed [NRM_W-1:0]      norm_depth;
    logic                         last;
  } tlpe_out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] az;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] bz;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cz;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ez;
    logic [NRM_W-1:0]      fx;
    logic [NRM_W-1:0]      fz;
    logic [FRAC_BITS-1:0]  top;
    logic [FRAC_BITS-1:0]  base;
  } tlpe_job_t;

  typedef struct packed {
    logic [1:0] crn;
    logic       top;
  } tlpe_vsel_t;

  function automatic tlpe_vsel_t vert_sel(input logic [2:0] face, input logic [2:0] j);
    logic [1:0] qi;
    tlpe_vsel_t s;
    case (j)
      3'd0: qi = 2'd0;
      3'd1: qi = 2'd1;
      3'd2: qi = 2'd2;
      3'd3: qi = 2'd0;
      3'd4: qi = 2'd2;
      default: qi = 2'd3;
    endcase
    s.crn = CRN_A;
    s.top = 1'b1;
    case (face)
      FACE_TOP: begin
        case (qi)
          2'd0: s.crn = CRN_A;
          2'd1: s.crn = CRN_B;
          2'd2: s.crn = CRN_C;
          default: s.crn = CRN_E;
        endcase
      end
      FACE_LEFT: begin
        s.crn = (qi == 2'd0 || qi == 2'd3) ? CRN_A : CRN_E;
        s.top = qi[1];
      end
      FACE_RIGHT: begin
        s.crn = (qi == 2'd0 || qi == 2'd3) ? CRN_B : CRN_C;
        s.top = !qi[1];
      end
      FACE_NEAR: begin
        s.crn = qi[1] ? CRN_B : CRN_A;
        s.top = (qi == 2'd0 || qi == 2'd3);
      end
      default: begin
        s.crn = (qi == 2'd0 || qi == 2'd3) ? CRN_E : CRN_C;
        s.top = !qi[1];
      end
    endcase
    return s;
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic [PSUM_W-1:0] v);
    logic [COORD_BITS-1:0] r;
    if (!v[PSUM_W-1] && (|v[PSUM_W-2:COORD_BITS-1]))
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    else if (v[PSUM_W-1] && !(&v[PSUM_W-2:COORD_BITS-1]))
      r = {1'b1, {(COORD_BITS-1){1'b0}}};
    else
      r = v[COORD_BITS-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tlpe_isqrt.sv @@
`default_nettype none
module tlpe_isqrt
  import tlpe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  rad,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  logic                busy_r, done_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r, rem_a, rem_b;
  logic [ROOT_W-1:0]   root_r, root_a, root_b;
  logic [REM_W+1:0]    r2a, r2b, ta, tb;

  always_comb begin
    r2a = {rem_r, rad_r[RAD_W-1 -: 2]};
    ta  = {2'b00, root_r, 2'b01};
    if (r2a >= ta) begin
      rem_a  = REM_W'(r2a - ta);
      root_a = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      rem_a  = r2a[REM_W-1:0];
      root_a = {root_r[ROOT_W-2:0], 1'b0};
    end
    r2b = {rem_a, rad_r[RAD_W-3 -: 2]};
    tb  = {2'b00, root_a, 2'b01};
    if (r2b >= tb) begin
      rem_b  = REM_W'(r2b - tb);
      root_b = {root_a[ROOT_W-2:0], 1'b1};
    end else begin
      rem_b  = r2b[REM_W-1:0];
      root_b = {root_a[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= SQ_CNT_W'(SQ_CYC - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rad_r  <= RAD_W'(rad);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-5:0], 4'b0000};
      rem_r  <= rem_b;
      root_r <= root_b;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

@@ rtl/tlpe_div.sv @@
`default_nettype none
module tlpe_div
  import tlpe_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [QW-1:0]         quo
);

  logic                busy_r, done_r;
  logic [DV_CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0]    rem_r, rem_a, rem_b;
  logic [DSH_W-1:0]    dsh_r, dsh_a;
  logic [QW-1:0]       q_r;
  logic                qa, qb;

  always_comb begin
    qa = (DSH_W'(rem_r) >= dsh_r);
    rem_a = qa ? NUM_W'(DSH_W'(rem_r) - dsh_r) : rem_r;
    dsh_a = dsh_r >> 1;
    qb = (DSH_W'(rem_a) >= dsh_a);
    rem_b = qb ? NUM_W'(DSH_W'(rem_a) - dsh_a) : rem_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= DV_CNT_W'(DV_CYC - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= num;
      dsh_r <= {den, {(QW-1){1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_b;
      dsh_r <= dsh_a >> 1;
      q_r   <= {q_r[QW-3:0], qa, qb};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

@@ rtl/tlpe_front.sv @@
`default_nettype none
module tlpe_front
  import tlpe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire tlpe_in_t  in_data,
  input  wire logic      raised,
  output logic           job_push,
  input  wire logic      job_full,
  output tlpe_job_t      job
);

  typedef enum logic [3:0] {
    F_IDLE, F_NORM, F_SQ, F_RGO, F_ROOT, F_MUL, F_DGO, F_DIV, F_PUSH
  } fstate_t;

  fstate_t state_r;
  logic     hold_v_r;
  tlpe_in_t hold_r;

  logic [COORD_BITS-1:0] x0_r, z0_r, x1_r, z1_r;
  logic [FRAC_BITS:0]    w_r;
  logic                  sx_r, sz_r;
  logic [MAG_W-1:0]      mx_r, mz_r;
  logic [NMAG_W-1:0]     nx_r, nz_r;
  logic [SQ_W-1:0]       sqx_r, sqz_r;
  logic [ROOT_W-1:0]     len_r;
  logic [NUM_W-1:0]      nfx_r, nfz_r, nox_r, noz_r;

  logic take;
  logic [COORD_BITS:0] dx, dz, mxw, mzw;
  logic                zero_item;
  logic [MAG_W-1:0]    orv;
  logic [P_W-1:0]      p;
  logic [MAG_W+NMAG_W-2:0] tx, tz;
  logic [SQ_W-1:0]     sqx, sqz;
  logic [SUM_W-1:0]    rad;
  logic                sq_done;
  logic [ROOT_W-1:0]   root;
  logic [NMAG_W+W_W-1:0] pox, poz;
  logic [DEN_W-1:0]    den_f, den_o;
  logic                d_start;
  logic [3:0]          dv_done;
  logic [QW-1:0]       qfx, qfz, qox, qoz;
  logic [NRM_W-1:0]    fmx, fmz;
  logic [PSUM_W-1:0]   ox, oz, x0e, z0e, x1e, z1e;

  assign full = hold_v_r;
  assign take = (state_r == F_IDLE) && hold_v_r;

  always_comb begin
    dx = {hold_r.end_x[COORD_BITS-1], hold_r.end_x}
       - {hold_r.start_x[COORD_BITS-1], hold_r.start_x};
    dz = {hold_r.end_depth[COORD_BITS-1], hold_r.end_depth}
       - {hold_r.start_depth[COORD_BITS-1], hold_r.start_depth};
    mxw = dx[COORD_BITS] ? -dx : dx;
    mzw = dz[COORD_BITS] ? -dz : dz;
    zero_item = ((dx == '0) && (dz == '0)) || (hold_r.width == '0);
    orv = mx_r | mz_r;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) p = P_W'(i);
    end
    tx = {mx_r, {(NMAG_W-1){1'b0}}} >> p;
    tz = {mz_r, {(NMAG_W-1){1'b0}}} >> p;
  end

  assign sqx = nx_r * nx_r;
  assign sqz = nz_r * nz_r;
  assign rad = sqx_r + sqz_r;
  assign pox = nz_r * w_r;
  assign poz = nx_r * w_r;
  assign den_f = {1'b0, len_r};
  assign den_o = {len_r, 1'b0};
  assign d_start = (state_r == F_DGO);

  tlpe_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .start(state_r == F_RGO), .rad(rad),
    .done(sq_done), .root(root)
  );

  tlpe_div u_div_fx (
    .clk(clk), .rst_n(rst_n), .start(d_start), .num(nfx_r), .den(den_f),
    .done(dv_done[0]), .quo(qfx)
  );
  tlpe_div u_div_fz (
    .clk(clk), .rst_n(rst_n), .start(d_start), .num(nfz_r), .den(den_f),
    .done(dv_done[1]), .quo(qfz)
  );
  tlpe_div u_div_ox (
    .clk(clk), .rst_n(rst_n), .start(d_start), .num(nox_r), .den(den_o),
    .done(dv_done[2]), .quo(qox)
  );
  tlpe_div u_div_oz (
    .clk(clk), .rst_n(rst_n), .start(d_start), .num(noz_r), .den(den_o),
    .done(dv_done[3]), .quo(qoz)
  );

  always_comb begin
    fmx = NRM_W'(qfx);
    fmz = NRM_W'(qfz);
    ox  = sz_r ? PSUM_W'(qox) : -PSUM_W'(qox);
    oz  = sx_r ? -PSUM_W'(qoz) : PSUM_W'(qoz);
    x0e = {{(PSUM_W-COORD_BITS){x0_r[COORD_BITS-1]}}, x0_r};
    z0e = {{(PSUM_W-COORD_BITS){z0_r[COORD_BITS-1]}}, z0_r};
    x1e = {{(PSUM_W-COORD_BITS){x1_r[COORD_BITS-1]}}, x1_r};
    z1e = {{(PSUM_W-COORD_BITS){z1_r[COORD_BITS-1]}}, z1_r};
    job.ax   = sat_coord(x0e + ox);
    job.az   = sat_coord(z0e + oz);
    job.bx   = sat_coord(x0e - ox);
    job.bz   = sat_coord(z0e - oz);
    job.cx   = sat_coord(x1e - ox);
    job.cz   = sat_coord(z1e - oz);
    job.ex   = sat_coord(x1e + ox);
    job.ez   = sat_coord(z1e + oz);
    job.fx   = sx_r ? -fmx : fmx;
    job.fz   = sz_r ? -fmz : fmz;
    job.top  = raised ? HT_TOP_RAISED : HT_TOP_FLAT;
    job.base = raised ? HT_BASE_RAISED : HT_BASE_FLAT;
  end

  assign job_push = (state_r == F_PUSH) && !job_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      hold_v_r <= 1'b0;
    end else begin
      if (push && !hold_v_r) hold_v_r <= 1'b1;
      else if (take) hold_v_r <= 1'b0;
      case (state_r)
        F_IDLE:  if (take && !zero_item) state_r <= F_NORM;
        F_NORM:  state_r <= F_SQ;
        F_SQ:    state_r <= F_RGO;
        F_RGO:   state_r <= F_ROOT;
        F_ROOT:  if (sq_done) state_r <= F_MUL;
        F_MUL:   state_r <= F_DGO;
        F_DGO:   state_r <= F_DIV;
        F_DIV:   if (&dv_done) state_r <= F_PUSH;
        F_PUSH:  if (!job_full) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !hold_v_r) hold_r <= in_data;
    if (take) begin
      x0_r <= hold_r.start_x;
      z0_r <= hold_r.start_depth;
      x1_r <= hold_r.end_x;
      z1_r <= hold_r.end_depth;
      w_r  <= hold_r.width;
      sx_r <= dx[COORD_BITS];
      sz_r <= dz[COORD_BITS];
      mx_r <= mxw[MAG_W-1:0];
      mz_r <= mzw[MAG_W-1:0];
    end
    if (state_r == F_NORM) begin
      nx_r <= tx[NMAG_W-1:0];
      nz_r <= tz[NMAG_W-1:0];
    end
    if (state_r == F_SQ) begin
      sqx_r <= sqx;
      sqz_r <= sqz;
    end
    if (state_r == F_ROOT && sq_done) len_r <= root;
    if (state_r == F_MUL) begin
      nfx_r <= NUM_W'({nx_r, {FRAC_BITS{1'b0}}}) + NUM_W'(len_r >> 1);
      nfz_r <= NUM_W'({nz_r, {FRAC_BITS{1'b0}}}) + NUM_W'(len_r >> 1);
      nox_r <= NUM_W'(pox) + NUM_W'(len_r);
      noz_r <= NUM_W'(poz) + NUM_W'(len_r);
    end
  end

endmodule
`default_nettype wire

@@ rtl/tlpe_fifo.sv @@
`default_nettype none
module tlpe_fifo
  import tlpe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire tlpe_job_t din,
  output logic           full,
  input  wire logic      pop,
  output tlpe_job_t      dout,
  output logic           empty
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  tlpe_job_t       mem_r [FIFO_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full  = (cnt_r == CW'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PW'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("job queue underflow");
`endif

endmodule
`default_nettype wire

@@ rtl/tlpe_back.sv @@
`default_nettype none
module tlpe_back
  import tlpe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      job_valid,
  input  wire tlpe_job_t job,
  output logic           job_pop,
  output logic           empty,
  input  wire logic      pop,
  output tlpe_out_t      out_data
);

  logic       jv_r, ov_r;
  tlpe_job_t  job_r;
  logic [2:0] face_r, j_r;
  tlpe_out_t  out_r;

  logic       adv, fin, load;
  tlpe_vsel_t sel;
  tlpe_out_t  vtx;

  assign adv  = jv_r && (!ov_r || pop);
  assign fin  = adv && (face_r == FACE_FAR) && (j_r == J_LAST);
  assign load = job_valid && (!jv_r || fin);
  assign job_pop = load;
  assign empty = !ov_r;
  assign out_data = out_r;

  always_comb begin
    sel = vert_sel(face_r, j_r);
    case (sel.crn)
      CRN_A:   begin vtx.pos_x = job_r.ax; vtx.pos_depth = job_r.az; end
      CRN_B:   begin vtx.pos_x = job_r.bx; vtx.pos_depth = job_r.bz; end
      CRN_C:   begin vtx.pos_x = job_r.cx; vtx.pos_depth = job_r.cz; end
      default: begin vtx.pos_x = job_r.ex; vtx.pos_depth = job_r.ez; end
    endcase
    vtx.pos_height = sel.top ? job_r.top : job_r.base;
    vtx.norm_y = '0;
    case (face_r)
      FACE_TOP: begin
        vtx.norm_x = '0;
        vtx.norm_depth = '0;
        vtx.norm_y = NORM_ONE;
      end
      FACE_LEFT:  begin vtx.norm_x = -job_r.fz; vtx.norm_depth = job_r.fx;  end
      FACE_RIGHT: begin vtx.norm_x = job_r.fz;  vtx.norm_depth = -job_r.fx; end
      FACE_NEAR:  begin vtx.norm_x = -job_r.fx; vtx.norm_depth = -job_r.fz; end
      default:    begin vtx.norm_x = job_r.fx;  vtx.norm_depth = job_r.fz;  end
    endcase
    vtx.last = (face_r == FACE_FAR) && (j_r == J_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jv_r   <= 1'b0;
      ov_r   <= 1'b0;
      face_r <= FACE_TOP;
      j_r    <= '0;
    end else begin
      if (load) jv_r <= 1'b1;
      else if (fin) jv_r <= 1'b0;
      if (adv) ov_r <= 1'b1;
      else if (pop) ov_r <= 1'b0;
      if (load) begin
        face_r <= FACE_TOP;
        j_r    <= '0;
      end else if (adv) begin
        if (j_r == J_LAST) begin
          j_r    <= '0;
          face_r <= face_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) job_r <= job;
    if (adv)  out_r <= vtx;
  end

endmodule
`default_nettype wire

@@ rtl/thick_line_prism_extruder_unit.sv @@
// channel  direction  handshake     payload
// in       input      push / full   in_data  (tlpe_in_t segment + width)
// out      output     pop / empty   out_data (tlpe_out_t vertex)
// cfg      input      cfg_we        cfg_data (raised mode)
//
// Each segment yields 30 vertices from the output register, one per cycle while
// pop stays high. The front works through take, three setup stages, the square
// root (16 two-bit steps plus done), two stages, the dividers (8 two-bit steps
// plus done) and push; the input hold can take the next segment meanwhile.
// Reset: raised mode 1, input hold, job queue and output register empty.
// Pop low holds the vertex; the two-entry job queue then fills and full rises.
// Zero-length segments and zero width are dropped in the front with no output.
`default_nettype none
module thick_line_prism_extruder_unit
  import tlpe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire tlpe_in_t  in_data,
  output logic           empty,
  input  wire logic      pop,
  output tlpe_out_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_data
);

  logic      mode_r;
  logic      q_push, q_full, q_pop, q_empty;
  tlpe_job_t q_din, q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b1;
    else if (cfg_we) mode_r <= cfg_data;
  end

  tlpe_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .raised(mode_r), .job_push(q_push), .job_full(q_full), .job(q_din)
  );

  tlpe_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  tlpe_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(!q_empty), .job(q_dout),
    .job_pop(q_pop), .empty(empty), .pop(pop), .out_data(out_data)
  );

`ifndef SYNTHESIS
  a_hold_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> full) else $error("input hold not taken");
  a_pop_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("back took a job from an empty queue");
`endif

endmodule
`default_nettype wire

@@ tb/sv/thick_line_prism_extruder_unit_tb.sv @@
`timescale 1ns / 1ps
module thick_line_prism_extruder_unit_tb;
  import tlpe_pkg::*;

  localparam logic [FRAC_BITS-1:0] BASE_UP = 14'd246;
  localparam logic [FRAC_BITS-1:0] TOP_UP = 14'd1311;
  localparam logic [FRAC_BITS-1:0] BASE_LOW = 14'd0;
  localparam logic [FRAC_BITS-1:0] TOP_LOW = 14'd33;

  class vertex_board;
    tlpe_out_t vert_q[$];
    int mismatches;
    int checked;

    function longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    function longint clamp_coord(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint int_root(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function tlpe_out_t make_vert(longint px, longint pz, logic [FRAC_BITS-1:0] h,
                                  longint nx, logic [FRAC_BITS:0] ny, longint nz);
      tlpe_out_t v;
      v.pos_x = px[COORD_BITS-1:0];
      v.pos_height = h;
      v.pos_depth = pz[COORD_BITS-1:0];
      v.norm_x = nx[NRM_W-1:0];
      v.norm_y = ny;
      v.norm_depth = nz[NRM_W-1:0];
      v.last = 1'b0;
      return v;
    endfunction

    function void add_face(longint px[4], longint pz[4], logic [FRAC_BITS-1:0] h[4],
                           longint nx, logic [FRAC_BITS:0] ny, longint nz);
      int order[6] = '{0, 1, 2, 0, 2, 3};
      foreach (order[i])
        vert_q.push_back(make_vert(px[order[i]], pz[order[i]], h[order[i]], nx, ny, nz));
    endfunction

    function void note_segment(tlpe_in_t s, bit raised);
      longint x0, z0, x1, z1, w, dx, dz, m, len, fx, fz, ox, oz, one;
      longint ax, az, bx, bz, cx, cz, ex, ez;
      logic [FRAC_BITS-1:0] lo, hi;
      x0 = s.start_x; z0 = s.start_depth; x1 = s.end_x; z1 = s.end_depth;
      w = s.width;
      one = 1 << FRAC_BITS;
      dx = x1 - x0; dz = z1 - z0;
      if ((dx == 0 && dz == 0) || w == 0) return;
      lo = raised ? BASE_UP : BASE_LOW;
      hi = raised ? TOP_UP : TOP_LOW;
      m = (dx < 0 ? -dx : dx);
      if ((dz < 0 ? -dz : dz) > m) m = (dz < 0 ? -dz : dz);
      while (m >= (64'sd1 << 30)) begin dx /= 2; dz /= 2; m /= 2; end
      while (m < (64'sd1 << 29)) begin dx *= 2; dz *= 2; m *= 2; end
      len = int_root(longint'(dx * dx + dz * dz));
      if (len <= 0) return;
      fx = round_div(dx * one, len);
      fz = round_div(dz * one, len);
      if (fx > one) fx = one;
      if (fx < -one) fx = -one;
      if (fz > one) fz = one;
      if (fz < -one) fz = -one;
      ox = round_div(-dz * w, 2 * len);
      oz = round_div(dx * w, 2 * len);
      ax = clamp_coord(x0 + ox); az = clamp_coord(z0 + oz);
      bx = clamp_coord(x0 - ox); bz = clamp_coord(z0 - oz);
      cx = clamp_coord(x1 - ox); cz = clamp_coord(z1 - oz);
      ex = clamp_coord(x1 + ox); ez = clamp_coord(z1 + oz);
      add_face('{ax, bx, cx, ex}, '{az, bz, cz, ez}, '{hi, hi, hi, hi}, 0, NORM_ONE, 0);
      add_face('{ax, ex, ex, ax}, '{az, ez, ez, az}, '{lo, lo, hi, hi}, -fz, '0, fx);
      add_face('{bx, cx, cx, bx}, '{bz, cz, cz, bz}, '{hi, hi, lo, lo}, fz, '0, -fx);
      add_face('{ax, ax, bx, bx}, '{az, az, bz, bz}, '{hi, lo, lo, hi}, -fx, '0, -fz);
      add_face('{ex, cx, cx, ex}, '{ez, cz, cz, ez}, '{hi, hi, lo, lo}, fx, '0, fz);
      vert_q[vert_q.size() - 1].last = 1'b1;
    endfunction

    function void check_vertex(tlpe_out_t got);
      tlpe_out_t want;
      checked++;
      if (vert_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %h", got);
        return;
      end
      want = vert_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("vertex mismatch: exp x=%0d h=%0d z=%0d n=(%0d,%0d,%0d) l=%0d",
                   want.pos_x, want.pos_height, want.pos_depth, want.norm_x,
                   want.norm_y, want.norm_depth, want.last);
          $display("                 got x=%0d h=%0d z=%0d n=(%0d,%0d,%0d) l=%0d",
                   got.pos_x, got.pos_height, got.pos_depth, got.norm_x,
                   got.norm_y, got.norm_depth, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  tlpe_in_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  tlpe_out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;

  vertex_board board = new();
  bit raised = 1'b1;
  bit calm = 1'b0;
  int pop_wait = 0;
  int segs_sent = 0;

  thick_line_prism_extruder_unit dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        board.check_vertex(out_data);
        pop_wait = calm ? 0 : $urandom_range(0, 7);
      end
      if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_seg(tlpe_in_t s);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_segment(s, raised);
    segs_sent++;
  endtask

  task automatic settle();
    @(posedge clk);
    push <= 1'b0;
    while (board.vert_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_mode(bit v);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    raised = v;
  endtask

  function automatic tlpe_in_t seg(int x0, int z0, int x1, int z1, int w);
    tlpe_in_t s;
    s.start_x = x0[15:0]; s.start_depth = z0[15:0];
    s.end_x = x1[15:0]; s.end_depth = z1[15:0];
    s.width = w[14:0];
    return s;
  endfunction

  function automatic tlpe_in_t random_seg();
    tlpe_in_t s;
    int cx, cz;
    logic [95:0] r;
    if ($urandom_range(0, 3) == 0) begin
      r = {$urandom, $urandom, $urandom};
      s = r[$bits(tlpe_in_t)-1:0];
    end else begin
      cx = $urandom_range(0, 32767) - 16384;
      cz = $urandom_range(0, 32767) - 16384;
      s.start_x = cx[15:0];
      s.start_depth = cz[15:0];
      cx = cx + $urandom_range(0, 8000) - 4000;
      cz = cz + $urandom_range(0, 8000) - 4000;
      s.end_x = cx[15:0];
      s.end_depth = cz[15:0];
      s.width = W_W'($urandom_range(1, 2000));
      if ($urandom_range(0, 15) == 0) s.width = '0;
      if ($urandom_range(0, 15) == 0) s.end_x = s.start_x;
      if ($urandom_range(0, 31) == 0) s.end_depth = s.start_depth;
    end
    return s;
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_seg(random_seg());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    calm = 1'b1;
    send_seg(seg(0, 0, 16384, 0, 1638));
    send_seg(seg(0, 0, 0, 16384, 16384));
    send_seg(seg(100, 100, 100, 100, 500));
    send_seg(seg(0, 0, 1000, 1000, 0));
    send_seg(seg(-32768, -32768, 32767, 32767, 32767));
    send_seg(seg(32767, -32768, -32768, 32767, 16384));
    send_seg(seg(-32768, 0, 32767, 0, 1));
    send_seg(seg(0, 32767, 0, -32768, 32767));
    send_seg(seg(5, 7, 6, 7, 300));
    send_seg(seg(0, 0, -3, 4, 200));
    send_seg(seg(30000, 30000, 32767, 31000, 16384));
    send_seg(seg(0, 0, 1, 1, 1));
    calm = 1'b0;
    set_mode(1'b0);
    send_seg(seg(0, 0, 16384, 0, 1638));
    send_seg(seg(-32768, -32768, 32767, 32767, 32767));
    send_seg(seg(-1000, 2000, 3000, -500, 800));
    send_seg(seg(10, 10, 10, 10, 800));
    random_phase(60);
    set_mode(1'b1);
    random_phase(60);
    calm = 1'b1;
    set_mode(1'b0);
    random_phase(40);
    calm = 1'b0;
    set_mode(1'b1);
    random_phase(60);
    settle();
    if (board.vert_q.size() > 0) board.mismatches++;
    $display("covered %0d segments, %0d vertices checked, both height modes",
             segs_sent, board.checked);
    if (board.mismatches == 0)
      $display("PASS thick_line_prism_extruder_unit");
    else
      $display("FAIL thick_line_prism_extruder_unit");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL thick_line_prism_extruder_unit");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tlpe_pkg.sv
rtl/tlpe_isqrt.sv
rtl/tlpe_div.sv
rtl/tlpe_front.sv
rtl/tlpe_fifo.sv
rtl/tlpe_back.sv
rtl/thick_line_prism_extruder_unit.sv
tb/sv/thick_line_prism_extruder_unit_tb.sv
